FILE: sv/xpe_pkg.sv
// ----------------------------------------------------------------------------
// xpe_pkg
// types, codes and pattern text for the xml prolog encoding detector
// ----------------------------------------------------------------------------
package xpe_pkg;

  typedef enum logic [2:0] {
    PH_WS    = 3'd0,
    PH_LT    = 3'd1,
    PH_KEY   = 3'd2,
    PH_QUOTE = 3'd3,
    PH_VALUE = 3'd4,
    PH_DONE  = 3'd5
  } phase_t;

  localparam logic [4:0] CODE_NOINFO = 5'd0;
  localparam logic [4:0] CODE_UTF8   = 5'd1;
  localparam logic [4:0] CODE_UNSUPP = 5'd20;

  localparam logic [1:0] FAM_NONE = 2'd0;
  localparam logic [1:0] FAM_UTF  = 2'd1;
  localparam logic [1:0] FAM_ISO  = 2'd2;
  localparam logic [1:0] FAM_WIN  = 2'd3;

  localparam logic [3:0] KEY_LEN = 4'd9;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] idx;
    logic [1:0] fam;
  } scan_state_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] code;
  } scan_result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    to_lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] i);
    case (i)
      4'd0:    key_char = "e";
      4'd1:    key_char = "n";
      4'd2:    key_char = "c";
      4'd3:    key_char = "o";
      4'd4:    key_char = "d";
      4'd5:    key_char = "i";
      4'd6:    key_char = "n";
      4'd7:    key_char = "g";
      4'd8:    key_char = "=";
      default: key_char = 8'h00;
    endcase
  endfunction

  function automatic logic [3:0] fam_len(input logic [1:0] f);
    case (f)
      FAM_UTF: fam_len = 4'd5;
      FAM_ISO: fam_len = 4'd9;
      FAM_WIN: fam_len = 4'd11;
      default: fam_len = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] fam_char(input logic [1:0] f, input logic [3:0] i);
    logic [87:0] txt;
    txt = 88'h0;
    case (f)
      FAM_UTF: txt = {"utf-8", 48'h0};
      FAM_ISO: txt = {"iso-8859-", 16'h0};
      FAM_WIN: txt = "windows-125";
      default: txt = 88'h0;
    endcase
    fam_char = (i < 4'd11) ? txt[8'd87 - {i, 3'b000} -: 8] : 8'h00;
  endfunction

endpackage

FILE: sv/xpe_step.sv
// ----------------------------------------------------------------------------
// xpe_step
// next-state and result logic for one document byte
// ----------------------------------------------------------------------------
module xpe_step
  import xpe_pkg::*;
(
  input  scan_state_t  cur,
  input  logic [7:0]   data_byte,
  input  logic         last_byte,
  output scan_state_t  nxt,
  output scan_result_t res
);

  always_comb begin
    logic [7:0] lc;
    logic [3:0] m;
    logic [3:0] vidx;
    logic [1:0] vfam;
    logic       vrun;
    logic       have;
    logic [4:0] code;
    logic       do_val;

    lc     = to_lower(data_byte);
    nxt    = cur;
    have   = 1'b0;
    code   = CODE_NOINFO;
    do_val = 1'b0;
    vrun   = 1'b0;
    vidx   = cur.idx;
    vfam   = cur.fam;
    m      = (cur.idx > 4'd8) ? 4'd0 : cur.idx;

    case (cur.phase)
      PH_WS: begin
        if (data_byte == " " || data_byte == 8'h0a || data_byte == 8'h0d ||
            data_byte == 8'h09) begin
          nxt.phase = PH_WS;
        end else if (data_byte == "<") begin
          nxt.phase = PH_LT;
        end else begin
          have = 1'b1;
          code = CODE_NOINFO;
        end
      end
      PH_LT: begin
        if (data_byte == "?") begin
          nxt.phase = PH_KEY;
          nxt.idx   = 4'd0;
        end else begin
          have = 1'b1;
          code = CODE_NOINFO;
        end
      end
      PH_KEY: begin
        nxt.idx = m;
        if (m == 4'd0) begin
          if (data_byte == "e") begin
            nxt.idx = 4'd1;
          end else if (data_byte == ">") begin
            have = 1'b1;
            code = CODE_UTF8;
          end
        end else if (lc == key_char(m)) begin
          if (m + 4'd1 == KEY_LEN) begin
            nxt.phase = PH_QUOTE;
            nxt.idx   = 4'd0;
          end else begin
            nxt.idx = m + 4'd1;
          end
        end else if (data_byte == ">") begin
          have = 1'b1;
          code = CODE_UTF8;
        end else begin
          nxt.idx = (data_byte == "e") ? 4'd1 : 4'd0;
        end
      end
      PH_QUOTE: begin
        nxt.phase = PH_VALUE;
        nxt.idx   = 4'd0;
        nxt.fam   = FAM_NONE;
        vidx      = 4'd0;
        vfam      = FAM_NONE;
        do_val    = (data_byte != 8'h22 && data_byte != 8'h27);
      end
      PH_VALUE: begin
        do_val = 1'b1;
      end
      default: begin
        nxt.phase = cur.phase;
      end
    endcase

    // value matcher
    if (do_val) begin
      vrun = 1'b0;
      if (vidx == 4'd0) begin
        vrun = 1'b1;
        nxt.idx = 4'd1;
        if (lc == "u") begin
          nxt.fam = FAM_UTF;
        end else if (lc == "i") begin
          nxt.fam = FAM_ISO;
        end else if (lc == "w") begin
          nxt.fam = FAM_WIN;
        end else begin
          vrun = 1'b0;
          nxt.idx = vidx;
        end
        if (!vrun) begin
          have = 1'b1;
          code = CODE_UNSUPP;
        end
      end else if (vfam == FAM_NONE || vidx > fam_len(vfam)) begin
        have = 1'b1;
        code = CODE_UNSUPP;
      end else if (vidx < fam_len(vfam)) begin
        if (lc != fam_char(vfam, vidx)) begin
          have = 1'b1;
          code = CODE_UNSUPP;
        end else begin
          nxt.idx = vidx + 4'd1;
          if (vfam == FAM_UTF && vidx + 4'd1 == fam_len(FAM_UTF)) begin
            have = 1'b1;
            code = CODE_UTF8;
          end
        end
      end else if (vfam == FAM_ISO) begin
        have = 1'b1;
        code = (data_byte >= "1" && data_byte <= "9") ?
               5'(data_byte - 8'h2f) : CODE_UNSUPP;
      end else begin
        have = 1'b1;
        code = (data_byte >= "0" && data_byte <= "8") ?
               5'(data_byte - 8'h25) : CODE_UNSUPP;
      end
    end

    // end of document before a decision
    if (!have && last_byte) begin
      case (nxt.phase)
        PH_WS, PH_LT: begin
          have = 1'b1;
          code = CODE_NOINFO;
        end
        PH_KEY: begin
          have = 1'b1;
          code = CODE_UTF8;
        end
        PH_QUOTE, PH_VALUE: begin
          have = 1'b1;
          code = CODE_UNSUPP;
        end
        default: begin
          have = 1'b0;
        end
      endcase
    end

    if (have) begin
      nxt.phase = PH_DONE;
    end
    if (last_byte) begin
      nxt.phase = PH_WS;
      nxt.idx   = 4'd0;
      nxt.fam   = FAM_NONE;
    end

    res.valid = have;
    res.code  = code;
  end

endmodule

FILE: sv/xml_prolog_encoding_detect_core.sv
// ----------------------------------------------------------------------------
// xml_prolog_encoding_detect_core
// detects the encoding named in an xml declaration, one byte per cycle while the result side keeps up
//
//   channel  direction  ports                                   handshake
//   in       input      in_data_byte[7:0], in_last_byte         in_valid / in_stall
//   out      output     out_encoding_code[4:0]                  out_valid / out_stall
//
// one byte is taken every cycle while the result side keeps up
// a request is held in the input register, then the result is registered
// out_stall backs up through the input register to in_stall
// reset returns the scanner to the leading whitespace phase with both stages empty
// ----------------------------------------------------------------------------
module xml_prolog_encoding_detect_core
  import xpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_encoding_code
);

  logic         s1_valid_r, s1_valid_nxt;
  logic [7:0]   s1_byte_r;
  logic         s1_last_r;
  scan_state_t  state_r, state_nxt;
  scan_result_t res;
  logic         out_valid_r, out_valid_nxt;
  logic [4:0]   out_code_r;
  logic         out_free;
  logic         fire;
  logic         in_take;

  xpe_step u_step (
    .cur       (state_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .nxt       (state_nxt),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !fire);
  assign out_valid_nxt = (fire && res.valid) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_WS, idx: 4'd0, fam: FAM_NONE};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
    end
    if (fire && res.valid) begin
      out_code_r <= res.code;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_encoding_code = out_code_r;

`ifndef ASSERT_OFF
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_encoding_code <= CODE_UNSUPP))
    else $error("encoding code out of range");

  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.valid && !s1_last_r) |=> (state_r.phase == PH_DONE))
    else $error("scanner not parked after result");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r) |=> (state_r.phase == PH_WS && state_r.idx == 4'd0))
    else $error("scanner not rearmed after last byte");
`endif

endmodule
